@@ design/cc20_pkg.sv @@
// ----------------------------------------------------------------------------
// cc20_pkg
// Shared types, constants and the state set-up function of the stream cipher.
// ----------------------------------------------------------------------------
package cc20_pkg;

	typedef logic [31:0] word_t;
	typedef logic [15:0][31:0] state_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_low;
		logic [31:0]      nonce_high;
	} key_cfg_t;

	typedef struct packed {
		logic start;
		logic kill;
		logic take;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
		logic full;
	} core_sts_t;

	typedef enum logic [2:0] {
		CFG_KEY_WORD_0,
		CFG_KEY_WORD_1,
		CFG_KEY_WORD_2,
		CFG_KEY_WORD_3,
		CFG_NONCE_LOW,
		CFG_NONCE_HIGH,
		CFG_INITIAL_COUNTER
	} cfg_idx_t;

	localparam word_t SIGMA_0 = 32'h61707865;
	localparam word_t SIGMA_1 = 32'h3320646e;
	localparam word_t SIGMA_2 = 32'h79622d32;
	localparam word_t SIGMA_3 = 32'h6b206574;

	function automatic state_t cc20_init_state(key_cfg_t c, word_t ctr);
		state_t s;
		s[0] = SIGMA_0;
		s[1] = SIGMA_1;
		s[2] = SIGMA_2;
		s[3] = SIGMA_3;
		for (int i = 0; i < 4; i++) begin
			s[4 + 2 * i] = c.key[i][31:0];
			s[5 + 2 * i] = c.key[i][63:32];
		end
		s[12] = ctr;
		s[13] = c.nonce_low[31:0];
		s[14] = c.nonce_low[63:32];
		s[15] = c.nonce_high;
		return s;
	endfunction

endpackage

@@ design/cc20_in_if.sv @@
// ----------------------------------------------------------------------------
// cc20_in_if
// Message word channel into the cipher: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface cc20_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_in;
	logic [3:0]  byte_count;
	logic        first;
	logic        last;

	modport source (output valid, data_in, byte_count, first, last, input ready);
	modport sink (input valid, data_in, byte_count, first, last, output ready);
endinterface

@@ design/cc20_out_if.sv @@
// ----------------------------------------------------------------------------
// cc20_out_if
// Result word channel out of the cipher: valid/ready plus payload.
// ----------------------------------------------------------------------------
interface cc20_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_out;
	logic [3:0]  byte_count_out;
	logic        last_out;

	modport source (output valid, data_out, byte_count_out, last_out, input ready);
	modport sink (input valid, data_out, byte_count_out, last_out, output ready);
endinterface

@@ design/cc20_qr.sv @@
// ----------------------------------------------------------------------------
// cc20_qr
// One quarter-round lane: add, xor and rotate over four state words.
// ----------------------------------------------------------------------------
module cc20_qr
	import cc20_pkg::*;
(
	input  word_t a,
	input  word_t b,
	input  word_t c,
	input  word_t d,
	output word_t qa,
	output word_t qb,
	output word_t qc,
	output word_t qd
);

	function automatic word_t rotl(word_t x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	word_t a1, b1, c1, d1;

	always_comb begin
		a1 = a + b;
		d1 = rotl(d ^ a1, 16);
		c1 = c + d1;
		b1 = rotl(b ^ c1, 12);
		qa = a1 + b1;
		qd = rotl(d1 ^ qa, 8);
		qc = c1 + qd;
		qb = rotl(b1 ^ qc, 7);
	end

endmodule

@@ design/cc20_core.sv @@
// ----------------------------------------------------------------------------
// cc20_core
// Round engine: four quarter-round lanes, one column or diagonal round per
// cycle over the 16-word state; holds the final state until it is taken.
// ----------------------------------------------------------------------------
module cc20_core
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	input  key_cfg_t  cfg,
	input  word_t     ctr,
	input  core_ctl_t ctl,
	output core_sts_t sts,
	output state_t    st,
	output word_t     st_ctr
);

	localparam int ROUNDS = 2 * DOUBLE_ROUNDS;
	localparam int RW = $clog2(ROUNDS);

	state_t          st_q;
	state_t          nxt;
	word_t           ctr_q;
	logic [RW-1:0]   rnd_q;
	logic            busy_q;
	logic            full_q;
	word_t           col_res [16];
	word_t           dia_res [16];
	word_t           la [4];
	word_t           lb [4];
	word_t           lc [4];
	word_t           ld [4];
	word_t           oa [4];
	word_t           ob [4];
	word_t           oc [4];
	word_t           od [4];

	// odd rounds work on the diagonals
	for (genvar j = 0; j < 4; j++) begin : g_lane
		localparam int DB = 4 + ((j + 1) % 4);
		localparam int DC = 8 + ((j + 2) % 4);
		localparam int DD = 12 + ((j + 3) % 4);

		assign la[j] = st_q[j];
		assign lb[j] = rnd_q[0] ? st_q[DB] : st_q[4 + j];
		assign lc[j] = rnd_q[0] ? st_q[DC] : st_q[8 + j];
		assign ld[j] = rnd_q[0] ? st_q[DD] : st_q[12 + j];

		cc20_qr u_qr (
			.a (la[j]),
			.b (lb[j]),
			.c (lc[j]),
			.d (ld[j]),
			.qa(oa[j]),
			.qb(ob[j]),
			.qc(oc[j]),
			.qd(od[j])
		);

		assign col_res[j]      = oa[j];
		assign col_res[4 + j]  = ob[j];
		assign col_res[8 + j]  = oc[j];
		assign col_res[12 + j] = od[j];
		assign dia_res[j]      = oa[j];
		assign dia_res[DB]     = ob[j];
		assign dia_res[DC]     = oc[j];
		assign dia_res[DD]     = od[j];
	end

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			nxt[i] = rnd_q[0] ? dia_res[i] : col_res[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
			rnd_q  <= '0;
		end else if (ctl.kill) begin
			busy_q <= 1'b0;
			full_q <= 1'b0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			rnd_q  <= '0;
		end else if (busy_q) begin
			rnd_q <= rnd_q + 1'b1;
			if (rnd_q == RW'(ROUNDS - 1)) begin
				busy_q <= 1'b0;
				full_q <= 1'b1;
			end
		end else if (ctl.take) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			st_q  <= cc20_init_state(cfg, ctr);
			ctr_q <= ctr;
		end else if (busy_q) begin
			st_q <= nxt;
		end
	end

	assign sts.busy = busy_q;
	assign sts.full = full_q;
	assign st       = st_q;
	assign st_ctr   = ctr_q;

endmodule

@@ design/cc20_merge.sv @@
// ----------------------------------------------------------------------------
// cc20_merge
// Merges the lane results: feed-forward addition of the input state and
// little-endian packing into the eight-word keystream block.
// ----------------------------------------------------------------------------
module cc20_merge
	import cc20_pkg::*;
(
	input  logic        clk,
	input  logic        load,
	input  state_t      st,
	input  key_cfg_t    cfg,
	input  word_t       ctr,
	input  logic [2:0]  pos,
	output logic [63:0] ks_word
);

	state_t      init;
	logic [63:0] ks_q [8];

	assign init = cc20_init_state(cfg, ctr);

	always_ff @(posedge clk) begin
		if (load) begin
			for (int i = 0; i < 8; i++) begin
				ks_q[i] <= {st[2 * i + 1] + init[2 * i + 1], st[2 * i] + init[2 * i]};
			end
		end
	end

	assign ks_word = ks_q[pos];

endmodule

@@ design/chacha20_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// chacha20_stream_cipher_top
// ChaCha20 (96-bit nonce, 32-bit block counter) word stream cipher.
//
// msg carries message words of up to eight bytes with first/last marks; res
// returns one transaction per message word: the bytes XORed with keystream,
// unused bytes zero. Key, nonce and initial counter are written through
// cfg_we/cfg_index/cfg_wdata; the user must write them only while no message
// word is in flight; the block itself does not enforce it. The round engine
// works one round per cycle over four quarter-round lanes on each 64-byte
// block, and computes the next block while the current one is used. A word
// whose keystream is ready passes through the input register and then the
// output register; a first word waits for a fresh block. One word waits in
// an input register and one result in an output register, so a stalled
// receiver holds the block with one word accepted ahead. Reset clears the
// valid flags, the word position, the configuration and the block counter,
// and the engine at once starts on block zero.
// ----------------------------------------------------------------------------
module chacha20_stream_cipher_top
	import cc20_pkg::*;
#(
	parameter int DOUBLE_ROUNDS = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_wdata,
	cc20_in_if.sink     msg,
	cc20_out_if.source  res
);

	key_cfg_t    cfg_q;
	word_t       init_ctr_q;
	core_ctl_t   ctl;
	core_sts_t   sts;
	state_t      core_st;
	word_t       core_ctr;
	logic [63:0] ks_word;
	logic [63:0] ct;

	logic        hold_v_q;
	logic        hold_first_q;
	logic        hold_last_q;
	logic [63:0] hold_data_q;
	logic [3:0]  hold_cnt_q;
	logic        ks_v_q;
	logic [2:0]  pos_q;
	word_t       blk_ctr_q;
	logic        out_v_q;
	logic [63:0] out_data_q;
	logic [3:0]  out_cnt_q;
	logic        out_last_q;

	logic        fst;
	logic        consume;
	logic        load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q      <= '0;
			init_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_KEY_WORD_0:      cfg_q.key[0]     <= cfg_wdata;
				CFG_KEY_WORD_1:      cfg_q.key[1]     <= cfg_wdata;
				CFG_KEY_WORD_2:      cfg_q.key[2]     <= cfg_wdata;
				CFG_KEY_WORD_3:      cfg_q.key[3]     <= cfg_wdata;
				CFG_NONCE_LOW:       cfg_q.nonce_low  <= cfg_wdata;
				CFG_NONCE_HIGH:      cfg_q.nonce_high <= cfg_wdata[31:0];
				CFG_INITIAL_COUNTER: init_ctr_q       <= cfg_wdata[31:0];
				default: ;
			endcase
		end
	end

	assign fst     = hold_v_q && hold_first_q;
	assign consume = hold_v_q && !hold_first_q && ks_v_q && (!out_v_q || res.ready);
	assign load    = sts.full && !ks_v_q && hold_v_q && !hold_first_q;

	// any config write or message start throws away a precomputed block
	assign ctl.kill  = fst || cfg_we;
	assign ctl.start = !sts.busy && !sts.full && !ctl.kill;
	assign ctl.take  = load;

	cc20_core #(
		.DOUBLE_ROUNDS(DOUBLE_ROUNDS)
	) u_core (
		.clk   (clk),
		.arst_n(arst_n),
		.cfg   (cfg_q),
		.ctr   (blk_ctr_q),
		.ctl   (ctl),
		.sts   (sts),
		.st    (core_st),
		.st_ctr(core_ctr)
	);

	cc20_merge u_merge (
		.clk    (clk),
		.load   (load),
		.st     (core_st),
		.cfg    (cfg_q),
		.ctr    (core_ctr),
		.pos    (pos_q),
		.ks_word(ks_word)
	);

	assign msg.ready = !hold_v_q || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q     <= 1'b0;
			hold_first_q <= 1'b0;
			ks_v_q       <= 1'b0;
			pos_q        <= '0;
			blk_ctr_q    <= '0;
			out_v_q      <= 1'b0;
		end else begin
			if (msg.valid && msg.ready) begin
				hold_v_q     <= 1'b1;
				hold_first_q <= msg.first;
			end else if (consume) begin
				hold_v_q <= 1'b0;
			end else if (fst) begin
				hold_first_q <= 1'b0;
			end

			if (fst) begin
				ks_v_q    <= 1'b0;
				pos_q     <= '0;
				blk_ctr_q <= init_ctr_q;
			end else if (load) begin
				ks_v_q    <= 1'b1;
				blk_ctr_q <= blk_ctr_q + 1'b1;
			end else if (consume) begin
				pos_q <= pos_q + 1'b1;
				if (pos_q == 3'd7) begin
					ks_v_q <= 1'b0;
				end
			end

			if (consume) begin
				out_v_q <= 1'b1;
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (msg.valid && msg.ready) begin
			hold_data_q <= msg.data_in;
			hold_cnt_q  <= msg.byte_count;
			hold_last_q <= msg.last;
		end
		if (consume) begin
			out_data_q <= ct;
			out_cnt_q  <= hold_cnt_q;
			out_last_q <= hold_last_q;
		end
	end

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			ct[8 * b +: 8] = (hold_cnt_q > 4'(b)) ?
				(hold_data_q[8 * b +: 8] ^ ks_word[8 * b +: 8]) : 8'h00;
		end
	end

	assign res.valid          = out_v_q;
	assign res.data_out       = out_data_q;
	assign res.byte_count_out = out_cnt_q;
	assign res.last_out       = out_last_q;

endmodule

@@ test/tb_chacha20_stream_cipher_top.sv @@
// ----------------------------------------------------------------------------
// tb_chacha20_stream_cipher_top
// Self-checking bench for the ChaCha20 word stream cipher. A directed table
// covers reset keystream, byte count edge cases, message restarts and counter
// wrap. Random messages then run under several key settings with idling on
// both channels and one long receiver hold-off. Every result transaction is
// checked against a local ChaCha20 predictor.
// ----------------------------------------------------------------------------
module tb_chacha20_stream_cipher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import cc20_pkg::*;

	localparam int N_DOUBLE_ROUNDS = 10;
	localparam int SETTLE_CYCLES = 2 * N_DOUBLE_ROUNDS + 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 175;
	localparam logic [2:0] CFG_UNUSED = 3'd7;
	localparam logic [31:0] EXPAND_0 = 32'h61707865;
	localparam logic [31:0] EXPAND_1 = 32'h3320646e;
	localparam logic [31:0] EXPAND_2 = 32'h79622d32;
	localparam logic [31:0] EXPAND_3 = 32'h6b206574;

	typedef struct packed {
		logic [63:0] data;
		logic [3:0]  count;
		logic        last;
	} cipher_word_t;

	typedef struct packed {
		logic [3:0][63:0] key;
		logic [63:0]      nonce_lo;
		logic [63:0]      nonce_hi;
		logic [63:0]      ctr;
	} cipher_setting_t;

	typedef struct packed {
		logic [1:0]  setting;
		logic [63:0] data;
		logic [3:0]  count;
		logic        first;
		logic        last;
		logic        typed;
		logic [63:0] exp_data;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_wdata;

	cc20_in_if  msg_if ();
	cc20_out_if res_if ();

	chacha20_stream_cipher_top #(
		.DOUBLE_ROUNDS(N_DOUBLE_ROUNDS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.msg      (msg_if),
		.res      (res_if)
	);

	// predictor state
	logic [3:0][63:0] key_r;
	logic [63:0]      nonce_lo_r;
	logic [31:0]      nonce_hi_r;
	logic [31:0]      ctr_init_r;
	logic [31:0]      blk_ctr;
	logic [7:0][63:0] ks_blk;
	logic [2:0]       word_pos;
	logic             ks_valid;

	cipher_word_t cipher_words_due [$];
	int  err_count = 0;
	int  stall_cycles = 0;
	int  sent = 0;
	bit  idle_en = 1'b1;
	bit  hold_req = 1'b0;
	bit  need_first = 1'b1;

	cipher_setting_t fixed_settings [2] = '{
		'0,
		'{key: '1, nonce_lo: '1, nonce_hi: '1, ctr: '1}
	};

	stim_row_t directed_rows [22] = '{
		'{2'd0, 64'h0000000000000000, 4'd8,  1'b1, 1'b0, 1'b1, 64'h903df1a0ade0b876},
		'{2'd0, 64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'hffffffffffffffff, 4'd0,  1'b0, 1'b0, 1'b1, 64'h0},
		'{2'd0, 64'hffffffffffffffff, 4'd15, 1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'h0123456789abcdef, 4'd9,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'ha5a5a5a5a5a5a5a5, 4'd3,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'h8000000000000001, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'h5a5a5a5a5a5a5a5a, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'hffffffffffffffff, 4'd1,  1'b0, 1'b1, 1'b0, 64'h0},
		'{2'd0, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd0, 64'h0000000000000000, 4'd8,  1'b1, 1'b1, 1'b1, 64'h903df1a0ade0b876},
		'{2'd1, 64'h0000000000000000, 4'd8,  1'b1, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'h0000000000000000, 4'd8,  1'b0, 1'b0, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd7,  1'b0, 1'b1, 1'b0, 64'h0},
		'{2'd1, 64'hffffffffffffffff, 4'd0,  1'b1, 1'b1, 1'b1, 64'h0}
	};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic state_t quarter(input state_t s, input int a, input int b,
			input int c, input int d);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
		return s;
	endfunction

	function automatic logic [7:0][63:0] chacha_block(input logic [31:0] ctr);
		state_t init_s;
		state_t w;
		logic [7:0][63:0] blk;
		init_s[0] = EXPAND_0;
		init_s[1] = EXPAND_1;
		init_s[2] = EXPAND_2;
		init_s[3] = EXPAND_3;
		for (int i = 0; i < 4; i++) begin
			init_s[4 + 2 * i] = key_r[i][31:0];
			init_s[5 + 2 * i] = key_r[i][63:32];
		end
		init_s[12] = ctr;
		init_s[13] = nonce_lo_r[31:0];
		init_s[14] = nonce_lo_r[63:32];
		init_s[15] = nonce_hi_r;
		w = init_s;
		for (int r = 0; r < N_DOUBLE_ROUNDS; r++) begin
			w = quarter(w, 0, 4, 8, 12);
			w = quarter(w, 1, 5, 9, 13);
			w = quarter(w, 2, 6, 10, 14);
			w = quarter(w, 3, 7, 11, 15);
			w = quarter(w, 0, 5, 10, 15);
			w = quarter(w, 1, 6, 11, 12);
			w = quarter(w, 2, 7, 8, 13);
			w = quarter(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			w[i] = w[i] + init_s[i];
		for (int i = 0; i < 8; i++)
			blk[i] = {w[2 * i + 1], w[2 * i]};
		return blk;
	endfunction

	task automatic predict_cipher_word(input logic [63:0] d, input logic [3:0] n,
			input logic f, input logic l, input logic typed, input logic [63:0] exp_d);
		logic [3:0]   used;
		logic [63:0]  mask;
		cipher_word_t w;
		if (f) begin
			blk_ctr = ctr_init_r;
			word_pos = 3'd0;
			ks_valid = 1'b0;
		end
		if (!ks_valid) begin
			ks_blk = chacha_block(blk_ctr);
			ks_valid = 1'b1;
		end
		used = (n > 4'd8) ? 4'd8 : n;
		mask = (used == 4'd8) ? '1 : ((64'd1 << (8 * used)) - 64'd1);
		w.data = typed ? exp_d : ((d ^ ks_blk[word_pos]) & mask);
		w.count = n;
		w.last = l;
		cipher_words_due.push_back(w);
		word_pos = word_pos + 3'd1;
		if (word_pos == 3'd0) begin
			ks_valid = 1'b0;
			blk_ctr = blk_ctr + 32'd1;
		end
	endtask

	// entered and left at a falling edge; valid stays high on return
	task automatic send_word(input logic [63:0] d, input logic [3:0] n, input logic f,
			input logic l, input logic typed, input logic [63:0] exp_d);
		if (idle_en && $urandom_range(0, 9) == 0) begin
			msg_if.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		msg_if.valid <= 1'b1;
		msg_if.data_in <= d;
		msg_if.byte_count <= n;
		msg_if.first <= f;
		msg_if.last <= l;
		do
			@(posedge clk);
		while (!msg_if.ready);
		predict_cipher_word(d, n, f, l, typed, exp_d);
		sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		msg_if.valid <= 1'b0;
		while (cipher_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		case (idx)
			CFG_KEY_WORD_0:      key_r[0] = val;
			CFG_KEY_WORD_1:      key_r[1] = val;
			CFG_KEY_WORD_2:      key_r[2] = val;
			CFG_KEY_WORD_3:      key_r[3] = val;
			CFG_NONCE_LOW:       nonce_lo_r = val;
			CFG_NONCE_HIGH:      nonce_hi_r = val[31:0];
			CFG_INITIAL_COUNTER: ctr_init_r = val[31:0];
			default: ;
		endcase
	endtask

	task automatic load_settings(input cipher_setting_t s);
		wait_drained();
		for (int i = 0; i < 4; i++)
			write_reg(3'(CFG_KEY_WORD_0 + i), s.key[i]);
		write_reg(CFG_NONCE_LOW, s.nonce_lo);
		write_reg(CFG_NONCE_HIGH, s.nonce_hi);
		write_reg(CFG_UNUSED, rand64());
		write_reg(CFG_INITIAL_COUNTER, s.ctr);
		cfg_we <= 1'b0;
		need_first = 1'b1;
	endtask

	task automatic send_message();
		int         len;
		bit         broken;
		bit         no_first;
		bit         no_last;
		logic [3:0] n;
		len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
		broken = ($urandom_range(0, 9) == 0);
		no_first = broken && !need_first && $urandom_range(0, 1);
		no_last = broken && $urandom_range(0, 1);
		for (int k = 0; k < len; k++) begin
			n = 4'd8;
			if (k == len - 1 && $urandom_range(0, 1))
				n = 4'($urandom_range(1, 8));
			if (broken && $urandom_range(0, 3) == 0)
				n = 4'($urandom_range(0, 15));
			send_word(rand64(), n, k == 0 && !no_first, k == len - 1 && !no_last, 1'b0, '0);
		end
		need_first = 1'b0;
	endtask

	task automatic random_phase(input cipher_setting_t s, input bit hold);
		int target;
		load_settings(s);
		if (hold)
			hold_req = 1'b1;
		target = sent + PHASE_ITEMS;
		while (sent < target)
			send_message();
	endtask

	function automatic cipher_setting_t random_setting();
		cipher_setting_t s;
		for (int i = 0; i < 4; i++)
			s.key[i] = rand64();
		s.nonce_lo = rand64();
		s.nonce_hi = rand64();
		s.ctr = rand64();
		return s;
	endfunction

	// result sink
	initial begin
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				res_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				res_if.ready <= 1'b1;
			end else if (idle_en && $urandom_range(0, 7) == 0) begin
				res_if.ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(negedge clk);
				res_if.ready <= 1'b1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// result check and watchdog
	always @(posedge clk) begin
		cipher_word_t w;
		if (arst_n) begin
			if ((msg_if.valid && msg_if.ready) || (res_if.valid && res_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
			if (res_if.valid && res_if.ready) begin
				if (cipher_words_due.size() == 0) begin
					$error("unexpected transaction: data_out %h", res_if.data_out);
					err_count++;
				end else begin
					w = cipher_words_due.pop_front();
					if (res_if.data_out !== w.data) begin
						$error("data_out: expected %h, actual %h", w.data, res_if.data_out);
						err_count++;
					end
					if (res_if.byte_count_out !== w.count) begin
						$error("byte_count_out: expected %0d, actual %0d", w.count,
							res_if.byte_count_out);
						err_count++;
					end
					if (res_if.last_out !== w.last) begin
						$error("last_out: expected %0d, actual %0d", w.last, res_if.last_out);
						err_count++;
					end
				end
			end
		end
	end

	initial begin
		cipher_setting_t s;
		logic [1:0]      cur_setting;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		msg_if.valid = 1'b0;
		msg_if.data_in = '0;
		msg_if.byte_count = '0;
		msg_if.first = 1'b0;
		msg_if.last = 1'b0;
		key_r = '0;
		nonce_lo_r = '0;
		nonce_hi_r = '0;
		ctr_init_r = '0;
		blk_ctr = '0;
		ks_blk = '0;
		word_pos = '0;
		ks_valid = 1'b0;
		cur_setting = 2'd0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].setting != cur_setting) begin
				cur_setting = directed_rows[i].setting;
				load_settings(fixed_settings[cur_setting]);
			end
			send_word(directed_rows[i].data, directed_rows[i].count, directed_rows[i].first,
				directed_rows[i].last, directed_rows[i].typed, directed_rows[i].exp_data);
		end

		// long receiver hold-off while the input keeps offering
		random_phase(random_setting(), 1'b1);

		// counter close to wrap so longer messages cross it
		s = random_setting();
		s.ctr[31:0] = 32'hfffffffd;
		random_phase(s, 1'b0);

		random_phase(fixed_settings[0], 1'b0);

		idle_en = 1'b0;
		random_phase(random_setting(), 1'b0);

		wait_drained();
		if (err_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
